>>> sv/rcm_pkg.sv
`timescale 1ns / 1ps
// rcm_pkg: shared types and constants of the RMS current meter.
// No dependencies; used by every module of the block.
package rcm_pkg;

    // Register file layout
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIDPOINT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 2'd3;

    localparam int MID_W    = 12;
    localparam int WIN_W    = 13;
    localparam int GAIN_W   = 16;
    localparam int FLOOR_W  = 16;
    localparam int SAMPLE_W = 12;
    localparam int OUT_W    = 20;

    localparam logic [MID_W-1:0]   MID_RST   = 12'd2048;
    localparam logic [WIN_W-1:0]   WIN_RST   = 13'd1024;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd20634;
    localparam logic [FLOOR_W-1:0] FLOOR_RST = 16'd50;

    localparam logic [OUT_W-1:0] OUT_MAX = 20'hFFFFF;

    // Mean square keeps 8 fraction bits; root x Q8 gain leaves 12
    localparam int MEAN_FRAC = 8;
    localparam int PROD_FRAC = 12;

    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic win_done;
        logic out_full;
    } t_stat;

endpackage

>>> sv/rcm_ctrl.sv
`timescale 1ns / 1ps
// rcm_ctrl: sequencer of the RMS current meter.
// Depends on rcm_pkg; drives the command struct of rcm_dp.
module rcm_ctrl #(
    parameter int DIV_STEPS  = 44,
    parameter int SQRT_STEPS = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rcm_pkg::t_stat i_stat,
    output rcm_pkg::t_cmd  o_cmd
);
    import rcm_pkg::*;

    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_DIV_INIT,
        S_DIV,
        S_SQRT_INIT,
        S_SQRT,
        S_MUL_EMIT
    } t_state;

    t_state            r_state;
    logic              r_busy;
    logic              r_mul_done;
    logic [STEP_W-1:0] r_step;

    assign o_stall = r_busy;

    always_comb begin
        o_cmd           = '0;
        case (r_state)
            S_IDLE:      o_cmd.load      = i_valid;
            S_SQUARE:    o_cmd.square    = 1'b1;
            S_ACCUM:     o_cmd.accum     = 1'b1;
            S_DIV_INIT:  o_cmd.div_init  = 1'b1;
            S_DIV:       o_cmd.div_step  = 1'b1;
            S_SQRT_INIT: o_cmd.sqrt_init = 1'b1;
            S_SQRT:      o_cmd.sqrt_step = 1'b1;
            S_MUL_EMIT: begin
                o_cmd.mul  = !r_mul_done;
                o_cmd.emit = r_mul_done && !i_stat.out_full;
            end
            default:     o_cmd           = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_busy     <= 1'b0;
            r_mul_done <= 1'b0;
            r_step     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SQUARE;
                        r_busy  <= 1'b1;
                    end
                end
                S_SQUARE: r_state <= S_ACCUM;
                S_ACCUM: begin
                    if (i_stat.win_done) begin
                        r_state <= S_DIV_INIT;
                    end else begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_DIV_INIT: begin
                    r_state <= S_DIV;
                    r_step  <= '0;
                end
                S_DIV: begin
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_SQRT_INIT;
                    end
                    r_step <= r_step + STEP_W'(1);
                end
                S_SQRT_INIT: begin
                    r_state <= S_SQRT;
                    r_step  <= '0;
                end
                S_SQRT: begin
                    if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                        r_state    <= S_MUL_EMIT;
                        r_mul_done <= 1'b0;
                    end
                    r_step <= r_step + STEP_W'(1);
                end
                S_MUL_EMIT: begin
                    // product first, then wait for the output register to free up
                    if (!r_mul_done) begin
                        r_mul_done <= 1'b1;
                    end else if (!i_stat.out_full) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> sv/rcm_dp.sv
`timescale 1ns / 1ps
// rcm_dp: datapath of the RMS current meter: config registers, square and
// accumulate, bit-serial divider and root, gain multiply, output register.
// Depends on rcm_pkg; sequenced by rcm_ctrl.
module rcm_dp #(
    parameter int ADC_BITS   = 12,
    parameter int MAX_WINDOW = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [ADC_BITS-1:0]                  i_sample,
    input  rcm_pkg::t_cmd                        i_cmd,
    output rcm_pkg::t_stat                       o_stat,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [rcm_pkg::OUT_W-1:0]            o_rms_ma,
    output logic                                 o_saturated
);
    import rcm_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);              // sample count
    localparam int SW = 2 * ADC_BITS + $clog2(MAX_WINDOW);   // square sum
    localparam int DW = SW + MEAN_FRAC;                      // dividend / mean
    localparam int RW = (DW + 1) / 2;                        // root
    localparam int PW = RW + GAIN_W;                         // product
    localparam int MW = PW - PROD_FRAC;                      // whole mA
    localparam int EW = (MW > OUT_W) ? MW : OUT_W;

    // config
    logic [MID_W-1:0]   r_mid;
    logic [WIN_W-1:0]   r_win;
    logic [GAIN_W-1:0]  r_gain;
    logic [FLOOR_W-1:0] r_floor;

    // accumulation
    logic [ADC_BITS-1:0]   r_mag;
    logic [2*ADC_BITS-1:0] r_sq;
    logic [SW-1:0]         r_sum;
    logic [CW-1:0]         r_cnt;

    // divider, root, product
    logic [DW-1:0]   r_dvd;
    logic [CW-1:0]   r_dvs;
    logic [CW-1:0]   r_rem;
    logic [2*RW-1:0] r_rad;
    logic [RW-1:0]   r_root;
    logic [RW:0]     r_srem;
    logic [PW-1:0]   r_prod;

    // output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_ma;
    logic             r_out_sat;

    logic [ADC_BITS-1:0] samp;
    logic [ADC_BITS-1:0] mid;
    logic [ADC_BITS-1:0] mag;
    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       cnt_inc;
    logic [CW:0]         div_trial;
    logic                div_ge;
    logic [RW+2:0]       sq_trial;
    logic [RW+2:0]       sq_sub;
    logic                sq_ge;
    logic [EW-1:0]       ma_ext;
    logic                sat;
    logic [OUT_W-1:0]    ma_clip;
    logic [OUT_W-1:0]    ma_out;

    always_comb begin
        samp = i_sample;
        mid  = ADC_BITS'(r_mid);
        mag  = (samp >= mid) ? (samp - mid) : (mid - samp);

        if (r_win == '0) begin
            n_eff = CW'(1);
        end else if (32'(r_win) > MAX_WINDOW) begin
            n_eff = CW'(MAX_WINDOW);
        end else begin
            n_eff = CW'(r_win);
        end
        cnt_inc = r_cnt + CW'(1);

        // restoring divide, one quotient bit per step
        div_trial = {r_rem, r_dvd[DW-1]};
        div_ge    = div_trial >= {1'b0, r_dvs};

        // digit-by-digit root, one root bit per step
        sq_trial = {r_srem, r_rad[2*RW-1 -: 2]};
        sq_sub   = (RW+3)'({r_root, 2'b01});
        sq_ge    = sq_trial >= sq_sub;

        // clip first, noise gate after
        ma_ext  = EW'(r_prod >> PROD_FRAC);
        sat     = ma_ext > EW'(OUT_MAX);
        ma_clip = sat ? OUT_MAX : OUT_W'(ma_ext);
        ma_out  = (ma_clip < OUT_W'(r_floor)) ? '0 : ma_clip;
    end

    assign o_stat.win_done = cnt_inc >= n_eff;
    assign o_stat.out_full = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= MID_RST;
            r_win       <= WIN_RST;
            r_gain      <= GAIN_RST;
            r_floor     <= FLOOR_RST;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIDPOINT:    r_mid   <= i_cfg_data[MID_W-1:0];
                    CFG_WINDOW:      r_win   <= i_cfg_data[WIN_W-1:0];
                    CFG_GAIN:        r_gain  <= i_cfg_data[GAIN_W-1:0];
                    CFG_NOISE_FLOOR: r_floor <= i_cfg_data[FLOOR_W-1:0];
                    default:         r_mid   <= r_mid;
                endcase
            end
            if (i_cmd.accum) begin
                r_sum <= r_sum + SW'(r_sq);
                r_cnt <= cnt_inc;
            end else if (i_cmd.div_init) begin
                r_sum <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= mag;
        end
        if (i_cmd.square) begin
            r_sq <= r_mag * r_mag;
        end
        if (i_cmd.div_init) begin
            r_dvd <= {r_sum, {MEAN_FRAC{1'b0}}};
            r_dvs <= r_cnt;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? CW'(div_trial - {1'b0, r_dvs}) : CW'(div_trial);
            r_dvd <= {r_dvd[DW-2:0], div_ge};
        end
        if (i_cmd.sqrt_init) begin
            r_rad  <= (2*RW)'(r_dvd);
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_srem <= sq_ge ? (RW+1)'(sq_trial - sq_sub) : (RW+1)'(sq_trial);
            r_root <= {r_root[RW-2:0], sq_ge};
            r_rad  <= {r_rad[2*RW-3:0], 2'b00};
        end
        if (i_cmd.mul) begin
            r_prod <= r_root * r_gain;
        end
        if (i_cmd.emit) begin
            r_out_ma  <= ma_out;
            r_out_sat <= sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_rms_ma    = r_out_ma;
    assign o_saturated = r_out_sat;

endmodule

>>> sv/rms_current_meter.sv
`timescale 1ns / 1ps
// rms_current_meter: sum-of-squares RMS meter. A sample passes the request
// accepted, square and accumulate states while the input stalls. Closing a
// window adds DW = 2*ADC_BITS+log2(MAX_WINDOW)+8 bit-serial divide steps and
// RW = (DW+1)/2 root steps, then the gain multiply and an emit that waits for
// a free output register. Reset is synchronous: registers take their
// defaults, the sum clears, no clearing pass.
module rms_current_meter #(
    parameter int ADC_BITS   = 12,
    parameter int MAX_WINDOW = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ADC_BITS-1:0]            i_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rcm_pkg::OUT_W-1:0]      o_rms_ma,
    output logic                           o_saturated
);
    import rcm_pkg::*;

    localparam int DW = 2 * ADC_BITS + $clog2(MAX_WINDOW) + MEAN_FRAC;
    localparam int RW = (DW + 1) / 2;

    t_cmd  cmd;
    t_stat stat;

    rcm_ctrl #(
        .DIV_STEPS  (DW),
        .SQRT_STEPS (RW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rcm_dp #(
        .ADC_BITS   (ADC_BITS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_rms_ma    (o_rms_ma),
        .o_saturated (o_saturated)
    );

endmodule

>>> sv/rcm_checker.sv
`timescale 1ns / 1ps
// rcm_checker: port-level assertions of the RMS current meter, and the bind
// that attaches them to rms_current_meter. Depends on rcm_pkg.
module rcm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [rcm_pkg::OUT_W-1:0] o_rms_ma,
    input logic                      o_saturated
);
    import rcm_pkg::*;

    // reset empties the output register and frees the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or input stall not cleared by reset");

    // a clipped reading always shows full scale, the noise gate never hides it
    a_sat_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_rms_ma == OUT_MAX)
        else $error("saturated result not at full scale");

    // an accepted sample occupies the datapath in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled while a sample is processed");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rms_ma) && $stable(o_saturated))
        else $error("stalled result changed or dropped");

endmodule

bind rms_current_meter rcm_checker u_rcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_rms_ma    (o_rms_ma),
    .o_saturated (o_saturated)
);

>>> test/rcm_reading_checker.sv
`timescale 1ns / 1ps
// rcm_reading_checker: watches the register port and both request channels of
// rms_current_meter, predicts every RMS reading and compares it field by field.
// Depends on rcm_pkg.
module rcm_reading_checker #(
    parameter int MAX_WINDOW = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rcm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_stall_up,
    input  logic [rcm_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [rcm_pkg::OUT_W-1:0]      i_rms_ma,
    input  logic                           i_saturated,
    output int                             o_fail_count,
    output int                             o_pending
);
    import rcm_pkg::*;

    localparam logic [WIN_W-1:0] WINDOW_CAP = WIN_W'(MAX_WINDOW);

    typedef struct packed {
        logic [OUT_W-1:0] rms_ma;
        logic             saturated;
    } t_reading;

    t_reading readings_due[$];

    logic [MID_W-1:0]   midpoint;
    logic [WIN_W-1:0]   window;
    logic [GAIN_W-1:0]  gain;
    logic [FLOOR_W-1:0] noise_floor;
    logic [35:0]        energy;
    logic [WIN_W-1:0]   fill;
    int                 fails = 0;

    // Bit-by-bit floor square root of the Q8 mean square; yields Q4 counts.
    function automatic logic [21:0] floor_root(input logic [43:0] value);
        logic [21:0] root;
        logic [21:0] trial;
        logic [43:0] sq;
        root = '0;
        for (int b = 21; b >= 0; b--) begin
            trial = root | (22'd1 << b);
            sq = {22'd0, trial} * {22'd0, trial};
            if (sq <= value)
                root = trial;
        end
        return root;
    endfunction

    function automatic t_reading rms_reading(input logic [35:0] acc,
                                             input logic [WIN_W-1:0] count,
                                             input logic [GAIN_W-1:0] g,
                                             input logic [FLOOR_W-1:0] fl);
        logic [43:0] mean_q8;
        logic [21:0] root_q4;
        logic [37:0] scaled;
        logic [25:0] whole_ma;
        t_reading    r;
        mean_q8  = {acc, 8'd0} / count;
        root_q4  = floor_root(mean_q8);
        scaled   = root_q4 * g;
        whole_ma = scaled[37:12];
        r.saturated = (whole_ma > OUT_MAX);
        r.rms_ma    = r.saturated ? OUT_MAX : whole_ma[OUT_W-1:0];
        // gate applies after clipping
        if (r.rms_ma < fl)
            r.rms_ma = '0;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [MID_W-1:0] mag;
        logic [WIN_W-1:0] span;
        t_reading         got;
        t_reading         want;
        if (!i_rst_n) begin
            midpoint    = MID_RST;
            window      = WIN_RST;
            gain        = GAIN_RST;
            noise_floor = FLOOR_RST;
            energy      = '0;
            fill        = '0;
            readings_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIDPOINT:    midpoint    = i_cfg_data[MID_W-1:0];
                    CFG_WINDOW:      window      = i_cfg_data[WIN_W-1:0];
                    CFG_GAIN:        gain        = i_cfg_data[GAIN_W-1:0];
                    CFG_NOISE_FLOOR: noise_floor = i_cfg_data[FLOOR_W-1:0];
                    default: ;
                endcase
            end

            // A reading leaving now cannot come from a sample entering now
            if (i_out_valid && !i_out_stall) begin
                got.rms_ma    = i_rms_ma;
                got.saturated = i_saturated;
                if (readings_due.size() == 0) begin
                    $error("unexpected reading: rms_ma %0d saturated %0d",
                           got.rms_ma, got.saturated);
                    fails++;
                end else begin
                    want = readings_due.pop_front();
                    if (got.rms_ma !== want.rms_ma) begin
                        $error("rms_ma: expected %0d, actual %0d",
                               want.rms_ma, got.rms_ma);
                        fails++;
                    end
                    if (got.saturated !== want.saturated) begin
                        $error("saturated: expected %0d, actual %0d",
                               want.saturated, got.saturated);
                        fails++;
                    end
                end
            end

            if (i_valid && !i_stall_up) begin
                mag    = (i_sample >= midpoint) ? i_sample - midpoint : midpoint - i_sample;
                energy = energy + mag * mag;
                fill   = fill + 1'b1;
                span   = (window == '0) ? WIN_W'(1)
                       : (window > WINDOW_CAP) ? WINDOW_CAP : window;
                // closes on reach or overshoot, so a shortened window fires on the next sample
                if (fill >= span) begin
                    readings_due.push_back(rms_reading(energy, fill, gain, noise_floor));
                    energy = '0;
                    fill   = '0;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= readings_due.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: sample and register stimulus for rms_current_meter with random
// idling on both channels; verdict from rcm_reading_checker. Depends on rcm_pkg.
module tb_top;
    import rcm_pkg::*;

    localparam int RANDOM_ITEMS  = 520;
    localparam int SETTLE_CYCLES = 100;

    typedef enum int {WAVE_ANY, WAVE_RAIL, WAVE_NEAR_MID} t_wave;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [OUT_W-1:0]      o_rms_ma;
    logic                  o_saturated;

    logic                  calm = 1'b0;
    logic [MID_W-1:0]      cur_mid;
    int                    fail_count;
    int                    pending;

    rms_current_meter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rms_ma    (o_rms_ma),
        .o_saturated (o_saturated)
    );

    rcm_reading_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_stall_up   (o_stall),
        .i_sample     (i_sample),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_rms_ma     (o_rms_ma),
        .i_saturated  (o_saturated),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        i_stall <= !calm && ($urandom_range(99) < 8);

    initial begin
        #4_000_000;
        $display("rms_current_meter test failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until every pending reading has left, then settle before returning.
    task automatic drain_readings();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] mid, input logic [CFG_DATA_W-1:0] win,
                             input logic [CFG_DATA_W-1:0] gn, input logic [CFG_DATA_W-1:0] fl);
        drain_readings();
        write_reg(CFG_MIDPOINT, mid);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_GAIN, gn);
        write_reg(CFG_NOISE_FLOOR, fl);
        cur_mid = mid[MID_W-1:0];
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 8)
                gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_wave wave,
                                                       input logic [MID_W-1:0] mid);
        int v;
        case (wave)
            WAVE_RAIL:     v = $urandom_range(1) ? 4095 : 0;
            WAVE_NEAR_MID: v = int'(mid) + int'($urandom_range(200)) - 100;
            default:       v = $urandom_range(4095);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    initial begin : stimulus
        int                    n_items;
        int                    random_sent;
        int                    phase;
        t_wave                 wave;
        logic [CFG_DATA_W-1:0] mid;
        logic [CFG_DATA_W-1:0] win;
        logic [CFG_DATA_W-1:0] gn;
        logic [CFG_DATA_W-1:0] fl;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_MIDPOINT;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_sample   = '0;
        cur_mid    = MID_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset midpoint, gain and floor, one reading per sample
        write_reg(CFG_WINDOW, 16'd1);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
        send_sample(12'd2100);

        configure(16'd0, 16'd1, 16'hFFFF, 16'd0);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'hAAA);
        send_sample(12'h555);

        configure(16'd4095, 16'd1, 16'd1, 16'd0);
        send_sample(12'd0);
        send_sample(12'd4095);

        // max floor: large reading survives, small one gated to zero
        configure(16'd2048, 16'd1, 16'd20634, 16'hFFFF);
        send_sample(12'd0);
        send_sample(12'd2000);

        // zero window behaves as one
        configure(16'd2048, 16'd0, 16'd256, 16'd0);
        send_sample(12'd2050);
        send_sample(12'd2046);

        // shorten the window while five samples are held
        configure(16'd2048, 16'd8, 16'd20634, 16'd50);
        repeat (5) send_sample(pick_sample(WAVE_ANY, cur_mid));
        configure(16'd2048, 16'd3, 16'd20634, 16'd50);
        send_sample(pick_sample(WAVE_ANY, cur_mid));

        // oversized window clamps to the cap, so nothing fires early;
        // then a one-sample window flushes the held sum at the next sample
        configure(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        repeat (200) send_sample(12'd4095);
        configure(16'd0, 16'd1, 16'hFFFF, 16'd0);
        send_sample(12'd4095);

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(3))
                0: mid = 16'd0;
                1: mid = 16'd4095;
                2: mid = 16'd2048;
                default: mid = CFG_DATA_W'($urandom_range(4095));
            endcase
            case ($urandom_range(9))
                0: win = 16'd0;
                1, 2, 3, 4, 5, 6: win = CFG_DATA_W'($urandom_range(8, 1));
                7, 8: win = CFG_DATA_W'($urandom_range(64, 9));
                default: win = CFG_DATA_W'($urandom_range(300, 65));
            endcase
            case ($urandom_range(3))
                0: gn = 16'd0;
                1: gn = 16'hFFFF;
                default: gn = CFG_DATA_W'($urandom_range(65535));
            endcase
            case ($urandom_range(4))
                0: fl = 16'd0;
                1: fl = 16'hFFFF;
                2: fl = CFG_DATA_W'($urandom_range(65535));
                default: fl = CFG_DATA_W'($urandom_range(500));
            endcase
            configure(mid, win, gn, fl);
            calm <= (phase >= 2 && phase <= 4);
            n_items = (phase >= 2 && phase <= 4) ? 60 : $urandom_range(60, 1);
            wave = t_wave'($urandom_range(2));
            repeat (n_items) begin
                send_sample(pick_sample(wave, cur_mid));
                random_sent++;
            end
            phase++;
        end
        calm <= 1'b0;
        drain_readings();

        if (fail_count == 0 && pending == 0)
            $display("rms_current_meter test passed");
        else
            $display("rms_current_meter test failed");
        $finish;
    end

endmodule

>>> files.f
sv/rcm_pkg.sv
sv/rcm_ctrl.sv
sv/rcm_dp.sv
sv/rms_current_meter.sv
sv/rcm_checker.sv
test/rcm_reading_checker.sv
test/tb_top.sv
